[rtl/core/dfru_pkg.sv]
// ----------------------------------------------------------------------------
// dfru_pkg: shared types and constants of the delta frame row updater
// Operation, status and parse mode codes, register indexes, command and
// result records passed between the front, the queues and the back.
// ----------------------------------------------------------------------------
package dfru_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int OP_W       = 2;
    localparam int SIZE_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int PIX_X_W    = 9;
    localparam int PIX_Y_W    = 8;
    localparam int STATUS_W   = 3;
    localparam int COLOR_W    = 16;
    localparam int FWIDTH_W   = 10;
    localparam int FHEIGHT_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = 10'd320;
    localparam logic [FHEIGHT_W-1:0] FHEIGHT_RST = 9'd240;
    localparam logic [COLOR_W-1:0]   FG_RST      = 16'hFFFF;
    localparam logic [COLOR_W-1:0]   BG_RST      = 16'h0000;

    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_DONE   = 3'd1,
        ST_ERR    = 3'd2,
        ST_NOREC  = 3'd3,
        ST_PIX    = 3'd4,
        ST_PIXOOR = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_RAW     = 3'd1,
        MODE_COUNT   = 3'd2,
        MODE_ROWNUM  = 3'd3,
        MODE_ROWDATA = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWIDTH  = 2'd0,
        CFG_FHEIGHT = 2'd1,
        CFG_FG      = 2'd2,
        CFG_BG      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        status_t           status;
        logic              wr_en;
        logic              rd_en;
        logic [2:0]        bit_sel;
        logic [BYTE_W-1:0] wdata;
        logic              frame_valid;
    } cmd_ctrl_t;

    typedef struct packed {
        status_t            status;
        logic [COLOR_W-1:0] color;
        logic               frame_valid;
    } result_t;

endpackage

[rtl/core/delta_frame_row_updater_top.sv]
// ----------------------------------------------------------------------------
// delta_frame_row_updater_top: packed 1-bit frame with record parser
// Applies raw and row-delta frame records to a byte store and answers
// pixel reads with the foreground or background colour.
//
//  channel  direction  handshake               content
//  s_       in         s_tvalid / s_tready     op, record_size, data_byte, xy
//  m_       out        m_tvalid / m_tready     status, pixel_color, frame_valid
//  cfg_     in         cfg_valid / cfg_ready   register index, write data
//
//  One item a cycle sustained while m_tready is high and neither queue fills;
//  a result passes through the command queue, the registered store read and
//  the output queue. Every item takes at most one store access.
//  After reset a clearing pass zeroes the store, one byte a cycle, all 16384
//  bytes at the default size; s_tready stays low until it ends.
//  Front and back stall on their own through a four-entry command queue;
//  configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module delta_frame_row_updater_top #(
    parameter int MAX_WIDTH  = dfru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dfru_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] record_size, [23:16] data_byte, [32:24] pixel_x, [40:33] pixel_y
    input  logic [dfru_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] op
    input  logic [dfru_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] pixel_color, [16] frame_valid
    output logic [dfru_pkg::M_TDATA_W-1:0]    m_tdata,
    // [2:0] status
    output logic [dfru_pkg::STATUS_W-1:0]     m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dfru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfru_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RL_MAX  = (MAX_WIDTH + 7) / 8;
    localparam int DEPTH   = RL_MAX * MAX_HEIGHT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CTRL_W  = $bits(dfru_pkg::cmd_ctrl_t);
    localparam int CMD_W   = ADDR_W + CTRL_W;

    logic [dfru_pkg::FWIDTH_W-1:0]  fwidth_reg;
    logic [dfru_pkg::FHEIGHT_W-1:0] fheight_reg;
    logic [dfru_pkg::COLOR_W-1:0]   fg_reg, bg_reg;

    dfru_pkg::cmd_ctrl_t  push_ctrl, pop_ctrl;
    logic [ADDR_W-1:0]    push_addr, pop_addr;
    logic [CMD_W-1:0]     pop_bits;
    logic                 cmd_push, cmd_pop, cmd_full, cmd_empty, clr_busy;
    logic [$clog2(dfru_pkg::CMD_QUEUE_DEPTH + 1)-1:0] cmd_count;
    dfru_pkg::result_t    result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwidth_reg  <= dfru_pkg::FWIDTH_RST;
            fheight_reg <= dfru_pkg::FHEIGHT_RST;
            fg_reg      <= dfru_pkg::FG_RST;
            bg_reg      <= dfru_pkg::BG_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (dfru_pkg::cfg_idx_t'(cfg_index))
                dfru_pkg::CFG_FWIDTH:  fwidth_reg  <= cfg_data[dfru_pkg::FWIDTH_W-1:0];
                dfru_pkg::CFG_FHEIGHT: fheight_reg <= cfg_data[dfru_pkg::FHEIGHT_W-1:0];
                dfru_pkg::CFG_FG:      fg_reg      <= cfg_data;
                dfru_pkg::CFG_BG:      bg_reg      <= cfg_data;
                default: begin
                    fg_reg <= fg_reg;
                end
            endcase
        end
    end

    dfru_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (s_tuser),
        .in_record_size (s_tdata[15:0]),
        .in_data_byte   (s_tdata[23:16]),
        .in_pixel_x     (s_tdata[32:24]),
        .in_pixel_y     (s_tdata[40:33]),
        .cfg_fwidth     (fwidth_reg),
        .cfg_fheight    (fheight_reg),
        .cmd_full       (cmd_full),
        .clr_busy       (clr_busy),
        .cmd_push       (cmd_push),
        .cmd_ctrl       (push_ctrl),
        .cmd_addr       (push_addr)
    );

    dfru_queue #(
        .WIDTH (CMD_W),
        .DEPTH (dfru_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .in_data  ({push_addr, push_ctrl}),
        .pop      (cmd_pop),
        .out_data (pop_bits),
        .full     (cmd_full),
        .empty    (cmd_empty),
        .count    (cmd_count)
    );

    assign pop_ctrl = dfru_pkg::cmd_ctrl_t'(pop_bits[CTRL_W-1:0]);
    assign pop_addr = pop_bits[CMD_W-1:CTRL_W];

    dfru_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (!cmd_empty),
        .cmd_pop    (cmd_pop),
        .cmd_ctrl   (pop_ctrl),
        .cmd_addr   (pop_addr),
        .cfg_fg     (fg_reg),
        .cfg_bg     (bg_reg),
        .clr_busy   (clr_busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tuser = result.status;
    assign m_tdata = {(dfru_pkg::M_TDATA_W - dfru_pkg::COLOR_W - 1)'(0),
                      result.frame_valid, result.color};

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_count <= ($clog2(dfru_pkg::CMD_QUEUE_DEPTH + 1))'(dfru_pkg::CMD_QUEUE_DEPTH))
        else $error("command queue count out of bounds");

endmodule

[rtl/core/dfru_ram.sv]
// ----------------------------------------------------------------------------
// dfru_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dfru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dfru_queue.sv]
// ----------------------------------------------------------------------------
// dfru_queue: small register FIFO
// First-word fall-through queue with occupancy count.
// ----------------------------------------------------------------------------
module dfru_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] in_data,
    input  logic             pop,
    output logic [WIDTH-1:0] out_data,
    output logic             full,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign count    = cnt_reg;
    assign out_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[rtl/core/dfru_front.sv]
// ----------------------------------------------------------------------------
// dfru_front: item intake and record parser
// Accepts one item a cycle while in_ready holds, runs the record parse state
// machine and turns each item into one store command with its final status.
// ----------------------------------------------------------------------------
module dfru_front #(
    parameter int MAX_WIDTH  = dfru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dfru_pkg::MAX_HEIGHT_DEF,
    parameter int ADDR_W     = 14
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dfru_pkg::OP_W-1:0]       in_op,
    input  logic [dfru_pkg::SIZE_W-1:0]     in_record_size,
    input  logic [dfru_pkg::BYTE_W-1:0]     in_data_byte,
    input  logic [dfru_pkg::PIX_X_W-1:0]    in_pixel_x,
    input  logic [dfru_pkg::PIX_Y_W-1:0]    in_pixel_y,
    input  logic [dfru_pkg::FWIDTH_W-1:0]   cfg_fwidth,
    input  logic [dfru_pkg::FHEIGHT_W-1:0]  cfg_fheight,
    input  logic                            cmd_full,
    input  logic                            clr_busy,
    output logic                            cmd_push,
    output dfru_pkg::cmd_ctrl_t             cmd_ctrl,
    output logic [ADDR_W-1:0]               cmd_addr
);

    localparam int RL_MAX = (MAX_WIDTH + 7) / 8;
    localparam int RL_W   = $clog2(RL_MAX + 1);
    localparam int DEPTH  = RL_MAX * MAX_HEIGHT;
    localparam int BL_W   = $clog2(DEPTH + 1);
    localparam int TR_W   = (BL_W > 8) ? BL_W : 8;
    localparam int WA_W   = TR_W + RL_W + 1;
    localparam int RA_W   = dfru_pkg::PIX_Y_W + RL_W + 1;
    localparam int EXP_W  = dfru_pkg::BYTE_W + RL_W + 1;
    localparam int FB_W   = RL_W + dfru_pkg::FHEIGHT_W;

    dfru_pkg::mode_t   mode_reg, mode_next;
    logic [BL_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [7:0]        rows_left_reg, rows_left_next;
    logic [TR_W-1:0]   target_row_reg, target_row_next;
    logic [RL_W-1:0]   byte_in_row_reg, byte_in_row_next;
    logic              valid_reg, valid_next;

    dfru_pkg::op_t                   op;
    logic [dfru_pkg::FWIDTH_W-1:0]   eff_w;
    logic [dfru_pkg::FHEIGHT_W-1:0]  eff_h;
    logic [RL_W-1:0]                 rl;
    logic [FB_W-1:0]                 fb;
    logic [EXP_W-1:0]                expect_len;
    logic [WA_W-1:0]                 waddr_full;
    logic [RA_W-1:0]                 raddr_full;
    logic [BL_W-1:0]                 left_dec;
    logic [7:0]                      rows_dec;
    logic [RL_W-1:0]                 bir_inc;
    logic                            accept;
    logic                            zero_geo, size_zero, size_big, size_raw, start_ok;
    logic                            count_bad, rownum_bad, row_end, in_store, in_range;
    dfru_pkg::status_t               status;
    logic                            wr_en, rd_en;

    assign op       = dfru_pkg::op_t'(in_op);
    assign in_ready = !cmd_full && !clr_busy;
    assign accept   = in_valid && in_ready;

    assign eff_w = (32'(cfg_fwidth) > 32'(MAX_WIDTH)) ?
                   dfru_pkg::FWIDTH_W'(MAX_WIDTH) : cfg_fwidth;
    assign eff_h = (32'(cfg_fheight) > 32'(MAX_HEIGHT)) ?
                   dfru_pkg::FHEIGHT_W'(MAX_HEIGHT) : cfg_fheight;
    assign rl    = RL_W'(({1'b0, eff_w} + 11'd7) >> 3);
    assign fb    = FB_W'(rl) * FB_W'(eff_h);

    assign zero_geo  = (eff_w == '0) || (eff_h == '0);
    assign size_zero = (in_record_size == '0);
    assign size_big  = 32'(in_record_size) > 32'(fb);
    assign size_raw  = 32'(in_record_size) == 32'(fb);
    assign start_ok  = !zero_geo && !size_zero && !size_big;

    assign expect_len = EXP_W'(in_data_byte) * (EXP_W'(rl) + 1'b1) + 1'b1;
    assign count_bad  = (in_data_byte == '0) || ({1'b0, in_data_byte} > eff_h) ||
                        (32'(bytes_left_reg) != 32'(expect_len));
    assign rownum_bad = ({1'b0, in_data_byte} >= eff_h);

    assign left_dec = (bytes_left_reg == '0) ? '0 : bytes_left_reg - 1'b1;
    assign rows_dec = (rows_left_reg == '0) ? '0 : rows_left_reg - 1'b1;
    assign bir_inc  = byte_in_row_reg + 1'b1;
    assign row_end  = (bir_inc >= rl);

    assign waddr_full = WA_W'(target_row_reg) * WA_W'(rl) + WA_W'(byte_in_row_reg);
    assign in_store   = (waddr_full < WA_W'(DEPTH));
    assign raddr_full = RA_W'(in_pixel_y) * RA_W'(rl) + RA_W'(in_pixel_x >> 3);
    assign in_range   = ({1'b0, in_pixel_x} < eff_w) && ({1'b0, in_pixel_y} < eff_h);

    always_comb begin
        mode_next = mode_reg;
        case (op)
            dfru_pkg::OP_START: begin
                if (!start_ok) begin
                    mode_next = dfru_pkg::MODE_IDLE;
                end else if (size_raw) begin
                    mode_next = dfru_pkg::MODE_RAW;
                end else begin
                    mode_next = dfru_pkg::MODE_COUNT;
                end
            end
            dfru_pkg::OP_DATA: begin
                case (mode_reg)
                    dfru_pkg::MODE_RAW: begin
                        if (left_dec == '0) begin
                            mode_next = dfru_pkg::MODE_IDLE;
                        end
                    end
                    dfru_pkg::MODE_COUNT: begin
                        mode_next = count_bad ? dfru_pkg::MODE_IDLE : dfru_pkg::MODE_ROWNUM;
                    end
                    dfru_pkg::MODE_ROWNUM: begin
                        mode_next = rownum_bad ? dfru_pkg::MODE_IDLE : dfru_pkg::MODE_ROWDATA;
                    end
                    dfru_pkg::MODE_ROWDATA: begin
                        if (row_end) begin
                            mode_next = (rows_dec == '0) ? dfru_pkg::MODE_IDLE :
                                                          dfru_pkg::MODE_ROWNUM;
                        end
                    end
                    default: begin
                        mode_next = dfru_pkg::MODE_IDLE;
                    end
                endcase
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_comb begin
        bytes_left_next  = bytes_left_reg;
        rows_left_next   = rows_left_reg;
        target_row_next  = target_row_reg;
        byte_in_row_next = byte_in_row_reg;
        valid_next       = valid_reg;
        status           = dfru_pkg::ST_ERR;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        case (op)
            dfru_pkg::OP_START: begin
                bytes_left_next  = '0;
                rows_left_next   = '0;
                target_row_next  = '0;
                byte_in_row_next = '0;
                if (zero_geo) begin
                    status = dfru_pkg::ST_ERR;
                end else if (size_zero) begin
                    valid_next = 1'b1;
                    status     = dfru_pkg::ST_DONE;
                end else if (size_big) begin
                    status = dfru_pkg::ST_ERR;
                end else begin
                    bytes_left_next = BL_W'(in_record_size);
                    status          = dfru_pkg::ST_OK;
                end
            end
            dfru_pkg::OP_DATA: begin
                case (mode_reg)
                    dfru_pkg::MODE_RAW: begin
                        wr_en            = in_store;
                        bytes_left_next  = left_dec;
                        byte_in_row_next = row_end ? '0 : bir_inc;
                        target_row_next  = row_end ? target_row_reg + 1'b1 : target_row_reg;
                        if (left_dec == '0) begin
                            valid_next = 1'b1;
                            status     = dfru_pkg::ST_DONE;
                        end else begin
                            status = dfru_pkg::ST_OK;
                        end
                    end
                    dfru_pkg::MODE_COUNT: begin
                        if (count_bad) begin
                            status = dfru_pkg::ST_ERR;
                        end else begin
                            bytes_left_next = left_dec;
                            rows_left_next  = in_data_byte;
                            status          = dfru_pkg::ST_OK;
                        end
                    end
                    dfru_pkg::MODE_ROWNUM: begin
                        bytes_left_next = left_dec;
                        if (rownum_bad) begin
                            status = dfru_pkg::ST_ERR;
                        end else begin
                            target_row_next  = TR_W'(in_data_byte);
                            byte_in_row_next = '0;
                            status           = dfru_pkg::ST_OK;
                        end
                    end
                    dfru_pkg::MODE_ROWDATA: begin
                        wr_en           = in_store;
                        bytes_left_next = left_dec;
                        status          = dfru_pkg::ST_OK;
                        if (row_end) begin
                            byte_in_row_next = '0;
                            rows_left_next   = rows_dec;
                            if (rows_dec == '0) begin
                                valid_next = 1'b1;
                                status     = dfru_pkg::ST_DONE;
                            end
                        end else begin
                            byte_in_row_next = bir_inc;
                        end
                    end
                    default: begin
                        status = dfru_pkg::ST_NOREC;
                    end
                endcase
            end
            dfru_pkg::OP_READ: begin
                if (in_range) begin
                    rd_en  = 1'b1;
                    status = dfru_pkg::ST_PIX;
                end else begin
                    status = dfru_pkg::ST_PIXOOR;
                end
            end
            default: begin
                status = dfru_pkg::ST_ERR;
            end
        endcase
    end

    assign cmd_push             = accept;
    assign cmd_ctrl.status      = status;
    assign cmd_ctrl.wr_en       = wr_en;
    assign cmd_ctrl.rd_en       = rd_en;
    assign cmd_ctrl.bit_sel     = in_pixel_x[2:0];
    assign cmd_ctrl.wdata       = in_data_byte;
    assign cmd_ctrl.frame_valid = valid_next;
    assign cmd_addr             = wr_en ? ADDR_W'(waddr_full) : ADDR_W'(raddr_full);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= dfru_pkg::MODE_IDLE;
            bytes_left_reg  <= '0;
            rows_left_reg   <= '0;
            target_row_reg  <= '0;
            byte_in_row_reg <= '0;
            valid_reg       <= 1'b0;
        end else if (accept) begin
            mode_reg        <= mode_next;
            bytes_left_reg  <= bytes_left_next;
            rows_left_reg   <= rows_left_next;
            target_row_reg  <= target_row_next;
            byte_in_row_reg <= byte_in_row_next;
            valid_reg       <= valid_next;
        end
    end

    a_idle_data_keeps_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == dfru_pkg::OP_DATA && mode_reg == dfru_pkg::MODE_IDLE)
        |=> (mode_reg == dfru_pkg::MODE_IDLE))
        else $error("data byte while idle opened a record");

    a_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |=> valid_reg)
        else $error("frame valid flag dropped");

    a_one_store_access: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> $onehot0({wr_en, rd_en, status == dfru_pkg::ST_PIXOOR}))
        else $error("item issued more than one store access");

endmodule

[rtl/core/dfru_back.sv]
// ----------------------------------------------------------------------------
// dfru_back: frame store executor
// Clears the store after reset, then pops commands, writes or reads the
// store and forms the result items in a two-entry output queue.
// ----------------------------------------------------------------------------
module dfru_back #(
    parameter int MAX_WIDTH  = dfru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dfru_pkg::MAX_HEIGHT_DEF,
    parameter int ADDR_W     = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  dfru_pkg::cmd_ctrl_t           cmd_ctrl,
    input  logic [ADDR_W-1:0]             cmd_addr,
    input  logic [dfru_pkg::COLOR_W-1:0]  cfg_fg,
    input  logic [dfru_pkg::COLOR_W-1:0]  cfg_bg,
    output logic                          clr_busy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dfru_pkg::result_t             out_result
);

    localparam int RL_MAX = (MAX_WIDTH + 7) / 8;
    localparam int DEPTH  = RL_MAX * MAX_HEIGHT;
    localparam int RES_W  = $bits(dfru_pkg::result_t);
    localparam int OCNT_W = $clog2(dfru_pkg::OUT_QUEUE_DEPTH + 1);

    logic                        clr_busy_reg;
    logic [ADDR_W-1:0]           clr_addr_reg;
    logic                        p1_valid_reg;
    dfru_pkg::cmd_ctrl_t         p1_ctrl_reg;

    logic                        ram_we, ram_re;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [dfru_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
    logic [OCNT_W-1:0]           out_count;
    logic [OCNT_W:0]             occ;
    logic                        out_full, out_empty, out_take, issue_ok;
    dfru_pkg::result_t           res;
    logic [RES_W-1:0]            out_bits;

    assign clr_busy = clr_busy_reg;
    assign out_take = out_ready && !out_empty;
    assign occ      = {1'b0, out_count} + (OCNT_W + 1)'(p1_valid_reg);
    assign issue_ok = (occ < (OCNT_W + 1)'(dfru_pkg::OUT_QUEUE_DEPTH)) ||
                      ((occ == (OCNT_W + 1)'(dfru_pkg::OUT_QUEUE_DEPTH)) && out_take);
    assign cmd_pop  = cmd_valid && issue_ok && !clr_busy_reg;

    assign ram_we    = clr_busy_reg || (cmd_pop && cmd_ctrl.wr_en);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : cmd_addr;
    assign ram_wdata = clr_busy_reg ? '0 : cmd_ctrl.wdata;
    assign ram_re    = cmd_pop && cmd_ctrl.rd_en;

    dfru_ram #(
        .WIDTH  (dfru_pkg::BYTE_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cmd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            p1_valid_reg <= cmd_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            p1_ctrl_reg <= cmd_ctrl;
        end
    end

    always_comb begin
        res.status      = p1_ctrl_reg.status;
        res.frame_valid = p1_ctrl_reg.frame_valid;
        res.color       = '0;
        if (p1_ctrl_reg.rd_en) begin
            res.color = ram_rdata[~p1_ctrl_reg.bit_sel] ? cfg_fg : cfg_bg;
        end
    end

    dfru_queue #(
        .WIDTH (RES_W),
        .DEPTH (dfru_pkg::OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (p1_valid_reg),
        .in_data  (res),
        .pop      (out_take),
        .out_data (out_bits),
        .full     (out_full),
        .empty    (out_empty),
        .count    (out_count)
    );

    assign out_valid  = !out_empty;
    assign out_result = dfru_pkg::result_t'(out_bits);

    a_out_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> !out_full)
        else $error("result pushed into a full output queue");

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ <= (OCNT_W + 1)'(dfru_pkg::OUT_QUEUE_DEPTH))
        else $error("results in flight exceed output queue space");

    a_clear_then_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_busy_reg) |-> (!p1_valid_reg && out_empty))
        else $error("result produced during the clearing pass");

endmodule

[tb/sv/delta_frame_row_updater_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_frame_row_updater_top_test: self-checking bench for the frame updater
// Streams raw and row-delta records, stray bytes, ignored operations and pixel
// reads into the block over several frame geometries and colour settings. A
// scoreboard mirrors the frame store and the record parser, predicts each
// result and compares it field by field, while both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module delta_frame_row_updater_top_test;

    localparam int STORE_DEPTH =
        ((dfru_pkg::MAX_WIDTH_DEF + 7) / 8) * dfru_pkg::MAX_HEIGHT_DEF;
    localparam logic [dfru_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

    class frame_scoreboard;
        int unsigned width_reg, height_reg;
        logic [dfru_pkg::COLOR_W-1:0] fg, bg;
        logic [7:0] frame [STORE_DEPTH];
        dfru_pkg::mode_t mode;
        int unsigned bytes_left, rows_left, target_row, byte_in_row;
        logic valid;
        dfru_pkg::result_t expected_q[$];
        int unsigned mismatches, checked;

        function new();
            width_reg = 32'(dfru_pkg::FWIDTH_RST);
            height_reg = 32'(dfru_pkg::FHEIGHT_RST);
            fg = dfru_pkg::FG_RST;
            bg = dfru_pkg::BG_RST;
            foreach (frame[i]) frame[i] = '0;
            mode = dfru_pkg::MODE_IDLE;
            bytes_left = 0;
            rows_left = 0;
            target_row = 0;
            byte_in_row = 0;
            valid = 1'b0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(dfru_pkg::cfg_idx_t idx,
                                logic [dfru_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                dfru_pkg::CFG_FWIDTH:  width_reg = 32'(v[dfru_pkg::FWIDTH_W-1:0]);
                dfru_pkg::CFG_FHEIGHT: height_reg = 32'(v[dfru_pkg::FHEIGHT_W-1:0]);
                dfru_pkg::CFG_FG:      fg = v;
                dfru_pkg::CFG_BG:      bg = v;
                default: ;
            endcase
        endfunction

        // drop writes that land outside the store
        function void store_byte(int unsigned row, int unsigned col, int unsigned rl,
                                 logic [7:0] b);
            int unsigned addr;
            addr = row * rl + col;
            if (addr < STORE_DEPTH) frame[addr] = b;
        endfunction

        function void note_item(logic [dfru_pkg::OP_W-1:0] op,
                                logic [dfru_pkg::SIZE_W-1:0] size,
                                logic [dfru_pkg::BYTE_W-1:0] b,
                                logic [dfru_pkg::PIX_X_W-1:0] x,
                                logic [dfru_pkg::PIX_Y_W-1:0] y);
            int unsigned w, h, rl, addr;
            dfru_pkg::result_t r;
            w = (width_reg > dfru_pkg::MAX_WIDTH_DEF) ? dfru_pkg::MAX_WIDTH_DEF : width_reg;
            h = (height_reg > dfru_pkg::MAX_HEIGHT_DEF) ? dfru_pkg::MAX_HEIGHT_DEF :
                                                          height_reg;
            rl = (w + 7) / 8;
            r.status = dfru_pkg::ST_ERR;
            r.color = '0;
            case (op)
                dfru_pkg::OP_START: begin
                    mode = dfru_pkg::MODE_IDLE;
                    target_row = 0;
                    byte_in_row = 0;
                    rows_left = 0;
                    bytes_left = 0;
                    if (w == 0 || h == 0) begin
                        r.status = dfru_pkg::ST_ERR;
                    end else if (size == 0) begin
                        valid = 1'b1;
                        r.status = dfru_pkg::ST_DONE;
                    end else if (size > rl * h) begin
                        r.status = dfru_pkg::ST_ERR;
                    end else begin
                        bytes_left = 32'(size);
                        mode = (size == rl * h) ? dfru_pkg::MODE_RAW : dfru_pkg::MODE_COUNT;
                        r.status = dfru_pkg::ST_OK;
                    end
                end
                dfru_pkg::OP_DATA: begin
                    r.status = dfru_pkg::ST_OK;
                    case (mode)
                        dfru_pkg::MODE_RAW: begin
                            store_byte(target_row, byte_in_row, rl, b);
                            byte_in_row++;
                            if (byte_in_row >= rl) begin
                                byte_in_row = 0;
                                target_row++;
                            end
                            if (bytes_left > 0) bytes_left--;
                            if (bytes_left == 0) begin
                                mode = dfru_pkg::MODE_IDLE;
                                valid = 1'b1;
                                r.status = dfru_pkg::ST_DONE;
                            end
                        end
                        dfru_pkg::MODE_COUNT: begin
                            if (b == 0 || b > h || bytes_left != 1 + b * (1 + rl)) begin
                                mode = dfru_pkg::MODE_IDLE;
                                r.status = dfru_pkg::ST_ERR;
                            end else begin
                                if (bytes_left > 0) bytes_left--;
                                rows_left = 32'(b);
                                mode = dfru_pkg::MODE_ROWNUM;
                            end
                        end
                        dfru_pkg::MODE_ROWNUM: begin
                            if (bytes_left > 0) bytes_left--;
                            if (b >= h) begin
                                mode = dfru_pkg::MODE_IDLE;
                                r.status = dfru_pkg::ST_ERR;
                            end else begin
                                target_row = 32'(b);
                                byte_in_row = 0;
                                mode = dfru_pkg::MODE_ROWDATA;
                            end
                        end
                        dfru_pkg::MODE_ROWDATA: begin
                            store_byte(target_row, byte_in_row, rl, b);
                            if (bytes_left > 0) bytes_left--;
                            byte_in_row++;
                            if (byte_in_row >= rl) begin
                                byte_in_row = 0;
                                if (rows_left > 0) rows_left--;
                                if (rows_left == 0) begin
                                    mode = dfru_pkg::MODE_IDLE;
                                    valid = 1'b1;
                                    r.status = dfru_pkg::ST_DONE;
                                end else begin
                                    mode = dfru_pkg::MODE_ROWNUM;
                                end
                            end
                        end
                        default: r.status = dfru_pkg::ST_NOREC;
                    endcase
                end
                dfru_pkg::OP_READ: begin
                    if (x < w && y < h) begin
                        addr = y * rl + x / 8;
                        if (addr < STORE_DEPTH && (frame[addr] & (8'h80 >> x[2:0])) != 0)
                            r.color = fg;
                        else
                            r.color = bg;
                        r.status = dfru_pkg::ST_PIX;
                    end else begin
                        r.status = dfru_pkg::ST_PIXOOR;
                    end
                end
                default: r.status = dfru_pkg::ST_ERR;
            endcase
            r.frame_valid = valid;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [dfru_pkg::STATUS_W-1:0] st,
                                   logic [dfru_pkg::COLOR_W-1:0] col, logic fv);
            dfru_pkg::result_t e;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %0d with nothing outstanding: %s %0d %s %h %s %b",
                             $time, checked, "status", st, "colour", col, "valid", fv);
            end else begin
                e = expected_q.pop_front();
                if (st !== e.status || col !== e.color || fv !== e.frame_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %0d: expected status %0d colour %h valid %b,",
                                 $time, checked, e.status, e.color, e.frame_valid,
                                 " got %0d %h %b", st, col, fv);
                end
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [dfru_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [dfru_pkg::OP_W-1:0]       s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [dfru_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [dfru_pkg::STATUS_W-1:0]   m_tuser;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [dfru_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dfru_pkg::CFG_DATA_W-1:0] cfg_data;

    frame_scoreboard sb;
    int unsigned items_sent;
    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned cur_w;
    int unsigned cur_h;
    bit          record_open;

    delta_frame_row_updater_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL delta_frame_row_updater_top");
        $finish;
    end

    initial begin
        int unsigned hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0 && stall_pct != 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(99) < stall_pct) begin
                hold = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[dfru_pkg::COLOR_W-1:0],
                            m_tdata[dfru_pkg::COLOR_W]);
    end

    task automatic send_item(logic [dfru_pkg::OP_W-1:0] op,
                             logic [dfru_pkg::SIZE_W-1:0] size,
                             logic [dfru_pkg::BYTE_W-1:0] b,
                             logic [dfru_pkg::PIX_X_W-1:0] x,
                             logic [dfru_pkg::PIX_Y_W-1:0] y);
        int unsigned gap;
        if ($urandom_range(99) < gap_pct) begin
            gap = $urandom_range(1, 15);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, y, x, b, size};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, size, b, x, y);
        items_sent++;
    endtask

    task automatic send_start(logic [dfru_pkg::SIZE_W-1:0] size);
        logic [31:0] r;
        r = $urandom;
        send_item(dfru_pkg::OP_START, size, r[7:0], r[16:8], r[31:24]);
    endtask

    task automatic send_byte(logic [dfru_pkg::BYTE_W-1:0] b);
        logic [63:0] r;
        r = {$urandom, $urandom};
        send_item(dfru_pkg::OP_DATA, r[15:0], b, r[40:32], r[55:48]);
    endtask

    task automatic send_read(logic [dfru_pkg::PIX_X_W-1:0] x,
                             logic [dfru_pkg::PIX_Y_W-1:0] y);
        logic [31:0] r;
        r = $urandom;
        send_item(dfru_pkg::OP_READ, r[15:0], r[23:16], x, y);
    endtask

    task automatic random_read();
        logic [dfru_pkg::PIX_X_W-1:0] x;
        logic [dfru_pkg::PIX_Y_W-1:0] y;
        case ($urandom_range(0, 4))
            0: x = '0;
            1: x = dfru_pkg::PIX_X_W'(cur_w - 1);
            2: x = dfru_pkg::PIX_X_W'(cur_w);
            3: x = '1;
            default: x = dfru_pkg::PIX_X_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: y = '0;
            1: y = dfru_pkg::PIX_Y_W'(cur_h - 1);
            2: y = dfru_pkg::PIX_Y_W'(cur_h);
            3: y = '1;
            default: y = dfru_pkg::PIX_Y_W'($urandom);
        endcase
        send_read(x, y);
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(dfru_pkg::cfg_idx_t idx, logic [dfru_pkg::CFG_DATA_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [dfru_pkg::FWIDTH_W-1:0] w,
                             logic [dfru_pkg::FHEIGHT_W-1:0] h,
                             logic [dfru_pkg::COLOR_W-1:0] fgc,
                             logic [dfru_pkg::COLOR_W-1:0] bgc);
        logic [31:0] r;
        wait_drain();
        r = $urandom;
        cfg_write(dfru_pkg::CFG_FWIDTH, {r[5:0], w});
        cfg_write(dfru_pkg::CFG_FHEIGHT, {r[12:6], h});
        cfg_write(dfru_pkg::CFG_FG, fgc);
        cfg_write(dfru_pkg::CFG_BG, bgc);
        cur_w = (w > dfru_pkg::MAX_WIDTH_DEF) ? dfru_pkg::MAX_WIDTH_DEF : 32'(w);
        cur_h = (h > dfru_pkg::MAX_HEIGHT_DEF) ? dfru_pkg::MAX_HEIGHT_DEF : 32'(h);
    endtask

    function automatic logic [dfru_pkg::COLOR_W-1:0] pick_colour();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return dfru_pkg::COLOR_W'($urandom);
        endcase
    endfunction

    // stop after cut items past the start so a record can be left open
    task automatic delta_record(bit spoil, int unsigned cut);
        int unsigned rl, cmax, c, size, bad, left;
        logic [7:0] cnt, row;
        rl = (cur_w + 7) / 8;
        cmax = 240 / (1 + rl);
        if (cmax > cur_h) cmax = cur_h;
        if (cmax > 255) cmax = 255;
        if (cmax < 1) cmax = 1;
        c = $urandom_range(1, cmax);
        size = 1 + c * (1 + rl);
        cnt = 8'(c);
        bad = spoil ? $urandom_range(1, 3) : 0;
        if (bad == 1) size = $urandom_range(0, 1) ? size + 1 : size - 1;
        if (bad == 2) cnt = $urandom_range(0, 1) ? 8'd0 : cnt + 8'd1;
        send_start(dfru_pkg::SIZE_W'(size));
        left = cut;
        if (left == 0) return;
        left--;
        send_byte(cnt);
        repeat (c) begin
            if (left == 0) return;
            left--;
            if (bad == 3 && $urandom_range(0, 2) == 0)
                row = 8'($urandom_range(cur_h, 255));
            else
                row = 8'($urandom_range(0, cur_h - 1));
            send_byte(row);
            repeat (rl) begin
                if (left == 0) return;
                left--;
                if ($urandom_range(99) < 8) random_read();
                send_byte(dfru_pkg::BYTE_W'($urandom));
            end
        end
    endtask

    task automatic raw_record(int unsigned nbytes);
        send_start(dfru_pkg::SIZE_W'(((cur_w + 7) / 8) * cur_h));
        repeat (nbytes) begin
            if ($urandom_range(99) < 8) random_read();
            send_byte(dfru_pkg::BYTE_W'($urandom));
        end
    endtask

    task automatic run_phase(int unsigned n);
        int unsigned stop, kind, fb;
        logic [dfru_pkg::SIZE_W-1:0] sz;
        stop = items_sent + n;
        fb = ((cur_w + 7) / 8) * cur_h;
        // carry on with a record left open under the previous geometry
        if (record_open)
            repeat ($urandom_range(1, 40)) send_byte(dfru_pkg::BYTE_W'($urandom));
        while (items_sent < stop) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
                delta_record($urandom_range(0, 9) == 0, 32'hFFFF_FFFF);
            end else if (kind < 62 && fb <= 96) begin
                raw_record(fb);
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 6)) random_read();
            end else if (kind < 90) begin
                case ($urandom_range(0, 4))
                    0: sz = dfru_pkg::SIZE_W'($urandom);
                    1: sz = dfru_pkg::SIZE_W'(fb + 1);
                    2: sz = dfru_pkg::SIZE_W'(fb - 1);
                    3: sz = 16'd1;
                    default: sz = '0;
                endcase
                send_start(sz);
                repeat ($urandom_range(0, 6)) send_byte(dfru_pkg::BYTE_W'($urandom));
            end else begin
                send_item(dfru_pkg::OP_W'($urandom_range(0, 3)),
                          dfru_pkg::SIZE_W'($urandom), dfru_pkg::BYTE_W'($urandom),
                          dfru_pkg::PIX_X_W'($urandom), dfru_pkg::PIX_Y_W'($urandom));
            end
        end
        record_open = ($urandom_range(0, 3) == 0);
        if (record_open) begin
            if (fb > 0 && $urandom_range(0, 1))
                raw_record($urandom_range(0, (fb < 32 ? fb : 32) - 1));
            else
                delta_record(1'b0, $urandom_range(0, 12));
        end
    endtask

    initial begin
        logic [dfru_pkg::FWIDTH_W-1:0] w;
        logic [dfru_pkg::FHEIGHT_W-1:0] h;
        int unsigned phase;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = dfru_pkg::CFG_FWIDTH;
        cfg_data = '0;
        items_sent = 0;
        gap_pct = 15;
        stall_pct = 4;
        cur_w = 32'(dfru_pkg::FWIDTH_RST);
        cur_h = 32'(dfru_pkg::FHEIGHT_RST);
        record_open = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_read(9'd0, 8'd0);
        send_read(9'd319, 8'd239);
        send_read(9'd320, 8'd0);
        send_read(9'd0, 8'd240);
        send_byte(8'hA5);
        send_item(OP_IGNORED, '1, '1, '1, '1);
        send_start(16'd0);
        send_start(16'hFFFF);
        send_start(16'd9601);

        configure(10'd8, 9'd4, 16'hF800, 16'h001F);
        send_start(16'd4);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_read(9'd0, 8'd0);
        send_read(9'd7, 8'd1);
        send_read(9'd8, 8'd0);
        send_start(16'd3);
        send_byte(8'd1);
        send_byte(8'd3);
        send_byte(8'h5A);
        // row number past the bottom
        send_start(16'd3);
        send_byte(8'd1);
        send_byte(8'd4);
        // abandon an open record
        send_start(16'd3);
        send_byte(8'd1);
        send_start(16'd0);
        // row count disagrees with the size
        send_start(16'd2);
        send_byte(8'd1);

        configure(10'd0, 9'd4, 16'h0000, 16'hFFFF);
        send_start(16'd0);
        send_read(9'd0, 8'd0);

        phase = 0;
        while (items_sent < 1600) begin
            if (phase == 0) begin
                w = 10'd1023;
                h = 9'd511;
            end else if (phase == 1) begin
                w = 10'd512;
                h = 9'd256;
            end else begin
                case ($urandom_range(0, 9))
                    6: begin
                        w = dfru_pkg::FWIDTH_W'($urandom_range(1, 512));
                        h = dfru_pkg::FHEIGHT_W'($urandom_range(1, 256));
                    end
                    7: begin
                        case ($urandom_range(0, 4))
                            0: w = 10'd1;
                            1: w = 10'd8;
                            2: w = 10'd9;
                            3: w = 10'd512;
                            default: w = 10'd1023;
                        endcase
                        case ($urandom_range(0, 3))
                            0: h = 9'd1;
                            1: h = 9'd2;
                            2: h = 9'd256;
                            default: h = 9'd511;
                        endcase
                    end
                    8: begin
                        w = dfru_pkg::FWIDTH_W'($urandom_range(505, 1023));
                        h = dfru_pkg::FHEIGHT_W'($urandom_range(1, 6));
                    end
                    9: begin
                        w = $urandom_range(0, 1) ? '0 :
                                                   dfru_pkg::FWIDTH_W'($urandom_range(1, 16));
                        h = (w == 0) ? dfru_pkg::FHEIGHT_W'($urandom_range(0, 20)) : '0;
                    end
                    default: begin
                        w = dfru_pkg::FWIDTH_W'($urandom_range(1, 64));
                        h = dfru_pkg::FHEIGHT_W'($urandom_range(1, 24));
                    end
                endcase
            end
            configure(w, h, pick_colour(), pick_colour());
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 4;
                default: stall_pct = 15;
            endcase
            run_phase((w == 0 || h == 0) ? 30 : $urandom_range(60, 160));
            phase++;
        end

        configure(dfru_pkg::FWIDTH_W'($urandom_range(1, 64)),
                  dfru_pkg::FHEIGHT_W'($urandom_range(1, 24)),
                  pick_colour(), pick_colour());
        gap_pct = 0;
        stall_pct = 0;
        run_phase(180);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drain();
        if (sb.mismatches == 0)
            $display("PASS delta_frame_row_updater_top");
        else
            $display("FAIL delta_frame_row_updater_top");
        $finish;
    end

endmodule

[sim.f]
rtl/core/dfru_pkg.sv
rtl/core/dfru_ram.sv
rtl/core/dfru_queue.sv
rtl/core/dfru_front.sv
rtl/core/dfru_back.sv
rtl/core/delta_frame_row_updater_top.sv
tb/sv/delta_frame_row_updater_top_test.sv
